FILE: hdl/phs_pkg.sv
// Shared types, constants and register codes for the Phong shading unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package phs_pkg;

    localparam int VEC_FRAC_BITS   = 14;
    localparam int COLOR_FRAC_BITS = 12;
    localparam int COLOR_W         = 13;
    localparam int VEC_W           = 16;
    localparam int OUT_W           = 14;
    localparam int EXP_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 13;
    localparam int NL_W            = 20;
    localparam int BASE_W          = 15;
    localparam int SGL_W           = 2 * COLOR_W;
    localparam int POW_STEPS       = EXP_W;
    localparam int GEOM_STAGES     = 6;
    localparam int MIX_STAGES      = 3;
    localparam int LATENCY         = GEOM_STAGES + POW_STEPS + MIX_STAGES;

    localparam logic [BASE_W-1:0] VEC_ONE = BASE_W'(1 << VEC_FRAC_BITS);
    localparam logic [OUT_W-1:0]  OUT_MAX = {OUT_W{1'b1}};

    localparam logic [COLOR_W-1:0] RST_AMBIENT  = 13'd1229;
    localparam logic [COLOR_W-1:0] RST_DIFFUSE  = 13'd1638;
    localparam logic [COLOR_W-1:0] RST_SPECULAR = 13'd1229;
    localparam logic [EXP_W-1:0]   RST_SHINE    = 8'd20;
    localparam logic [COLOR_W-1:0] RST_LIGHT    = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMBIENT     = 3'd0,
        REG_DIFFUSE     = 3'd1,
        REG_SPECULAR    = 3'd2,
        REG_SHINE       = 3'd3,
        REG_LIGHT_RED   = 3'd4,
        REG_LIGHT_GREEN = 3'd5,
        REG_LIGHT_BLUE  = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic [COLOR_W-1:0]      surf_red;
        logic [COLOR_W-1:0]      surf_green;
        logic [COLOR_W-1:0]      surf_blue;
        logic signed [VEC_W-1:0] view_x;
        logic signed [VEC_W-1:0] view_y;
        logic signed [VEC_W-1:0] view_z;
        logic signed [VEC_W-1:0] norm_x;
        logic signed [VEC_W-1:0] norm_y;
        logic signed [VEC_W-1:0] norm_z;
        logic signed [VEC_W-1:0] ldir_x;
        logic signed [VEC_W-1:0] ldir_y;
        logic signed [VEC_W-1:0] ldir_z;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_red;
        logic [OUT_W-1:0] out_green;
        logic [OUT_W-1:0] out_blue;
    } shade_t;

    // Data that rides alongside the vector math: the surface color per channel
    // (index 0 red, 1 green, 2 blue) and the rounded N.L.
    typedef struct packed {
        logic [2:0][COLOR_W-1:0] col;
        logic signed [NL_W-1:0]  nl;
    } side_t;

    typedef struct packed {
        logic              spec;
        logic [BASE_W-1:0] base;
        side_t             side;
    } geom_t;

    typedef struct packed {
        logic [COLOR_W-1:0]    ambient;
        logic [COLOR_W-1:0]    diffuse;
        logic [2:0][SGL_W-1:0] spec_light;
    } gain_t;

endpackage

`default_nettype wire

FILE: hdl/phs_geom.sv
// Vector stages of the Phong shading unit: N.L, reflection vector, V.R and the
// clamped power base. Six register stages. Depends on phs_pkg.
`default_nettype none

module phs_geom import phs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  pixel_t pixel,
    output logic   out_valid,
    output geom_t  out_data
);

    logic [GEOM_STAGES-1:0] vld_reg;

    logic signed [VEC_W-1:0] v_in [3];
    logic signed [VEC_W-1:0] n_in [3];
    logic signed [VEC_W-1:0] l_in [3];
    logic [2:0][COLOR_W-1:0] col_in;

    // Stage 1
    logic signed [VEC_W-1:0] v1_reg [3];
    logic signed [VEC_W-1:0] n1_reg [3];
    logic signed [VEC_W-1:0] l1_reg [3];
    logic signed [31:0]      nlp1_reg [3];
    logic [2:0][COLOR_W-1:0] col1_reg;
    // Stage 2
    logic signed [VEC_W-1:0] v2_reg [3];
    logic signed [VEC_W-1:0] n2_reg [3];
    logic signed [VEC_W-1:0] l2_reg [3];
    logic signed [NL_W-1:0]  nl2_reg;
    logic [2:0][COLOR_W-1:0] col2_reg;
    logic signed [33:0]      dot2_next;
    // Stage 3
    logic signed [VEC_W-1:0] v3_reg [3];
    logic signed [VEC_W-1:0] l3_reg [3];
    logic signed [35:0]      p3_reg [3];
    logic signed [NL_W-1:0]  nl3_reg;
    logic [2:0][COLOR_W-1:0] col3_reg;
    // Stage 4
    logic signed [VEC_W-1:0] v4_reg [3];
    logic signed [23:0]      r4_reg [3];
    logic signed [23:0]      r4_next [3];
    logic signed [NL_W-1:0]  nl4_reg;
    logic [2:0][COLOR_W-1:0] col4_reg;
    // Stage 5
    logic signed [39:0]      vrp5_reg [3];
    logic signed [NL_W-1:0]  nl5_reg;
    logic [2:0][COLOR_W-1:0] col5_reg;
    // Stage 6
    logic signed [41:0]      dot6_sum;
    logic signed [27:0]      vr6;
    geom_t                   out_reg;
    geom_t                   out_next;

    assign v_in[0] = pixel.view_x;
    assign v_in[1] = pixel.view_y;
    assign v_in[2] = pixel.view_z;
    assign n_in[0] = pixel.norm_x;
    assign n_in[1] = pixel.norm_y;
    assign n_in[2] = pixel.norm_z;
    assign l_in[0] = pixel.ldir_x;
    assign l_in[1] = pixel.ldir_y;
    assign l_in[2] = pixel.ldir_z;
    assign col_in  = {pixel.surf_blue, pixel.surf_green, pixel.surf_red};

    // Rounding by add-half then arithmetic shift matches floor((x + half) / 2^s).
    always_comb
    begin
        dot2_next = 34'(nlp1_reg[0]) + 34'(nlp1_reg[1]) + 34'(nlp1_reg[2])
                  + 34'sd8192;
        for (int i = 0; i < 3; i++)
        begin
            // rnd(2*x, 14) equals rnd(x, 13).
            r4_next[i] = 24'(p3_reg[i] + 36'sd4096 >>> 13) - 24'(l3_reg[i]);
        end
        dot6_sum = 42'(vrp5_reg[0]) + 42'(vrp5_reg[1]) + 42'(vrp5_reg[2]) + 42'sd8192;
        vr6      = dot6_sum[41:14];
        out_next.spec     = !vr6[27] && (vr6 != '0);
        out_next.base     = (vr6 > 28'sd16384) ? VEC_ONE : vr6[BASE_W-1:0];
        out_next.side.col = col5_reg;
        out_next.side.nl  = nl5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[GEOM_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            v1_reg[i]   <= v_in[i];
            n1_reg[i]   <= n_in[i];
            l1_reg[i]   <= l_in[i];
            nlp1_reg[i] <= n_in[i] * l_in[i];
            v2_reg[i]   <= v1_reg[i];
            n2_reg[i]   <= n1_reg[i];
            l2_reg[i]   <= l1_reg[i];
            v3_reg[i]   <= v2_reg[i];
            l3_reg[i]   <= l2_reg[i];
            p3_reg[i]   <= nl2_reg * n2_reg[i];
            v4_reg[i]   <= v3_reg[i];
            r4_reg[i]   <= r4_next[i];
            vrp5_reg[i] <= v4_reg[i] * r4_reg[i];
        end
        col1_reg <= col_in;
        col2_reg <= col1_reg;
        col3_reg <= col2_reg;
        col4_reg <= col3_reg;
        col5_reg <= col4_reg;
        nl2_reg  <= dot2_next[33:14];
        nl3_reg  <= nl2_reg;
        nl4_reg  <= nl3_reg;
        nl5_reg  <= nl4_reg;
        out_reg  <= out_next;
    end

    assign out_valid = vld_reg[GEOM_STAGES-1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hdl/phs_power.sv
// Square-and-multiply power of the clamped V.R base, one exponent bit per
// register stage, least significant bit first. Depends on phs_pkg.
`default_nettype none

module phs_power import phs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  geom_t            in_data,
    input  logic [EXP_W-1:0] exponent,
    output logic             out_valid,
    output logic             spec,
    output logic [BASE_W-1:0] power,
    output side_t            side
);

    logic [POW_STEPS-1:0] vld_reg;
    logic [BASE_W-1:0]    pw_reg   [POW_STEPS];
    logic [BASE_W-1:0]    b_reg    [POW_STEPS];
    logic                 spec_reg [POW_STEPS];
    side_t                side_reg [POW_STEPS];

    logic [BASE_W-1:0] stg_pw   [POW_STEPS+1];
    logic [BASE_W-1:0] stg_b    [POW_STEPS+1];
    logic              stg_spec [POW_STEPS+1];
    side_t             stg_side [POW_STEPS+1];

    assign stg_pw[0]   = VEC_ONE;
    assign stg_b[0]    = in_data.base;
    assign stg_spec[0] = in_data.spec;
    assign stg_side[0] = in_data.side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[POW_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < POW_STEPS; k++)
    begin : g_step
        logic [30:0]       pw_prod;
        logic [30:0]       b_prod;
        logic [BASE_W-1:0] pw_next;

        always_comb
        begin
            pw_prod = 31'(stg_pw[k] * stg_b[k]) + 31'd8192;
            b_prod  = 31'(stg_b[k] * stg_b[k]) + 31'd8192;
            pw_next = exponent[k] ? pw_prod[28:14] : stg_pw[k];
        end

        always_ff @(posedge clk)
        begin
            pw_reg[k]   <= pw_next;
            b_reg[k]    <= b_prod[28:14];
            spec_reg[k] <= stg_spec[k];
            side_reg[k] <= stg_side[k];
        end

        assign stg_pw[k+1]   = pw_reg[k];
        assign stg_b[k+1]    = b_reg[k];
        assign stg_spec[k+1] = spec_reg[k];
        assign stg_side[k+1] = side_reg[k];
    end

    assign out_valid = vld_reg[POW_STEPS-1];
    assign spec      = stg_spec[POW_STEPS];
    assign power     = stg_pw[POW_STEPS];
    assign side      = stg_side[POW_STEPS];

endmodule

`default_nettype wire

FILE: hdl/phs_mix.sv
// Color combination of the Phong shading unit: ambient, diffuse and specular
// terms per channel, summed and saturated over three stages. Depends on phs_pkg.
`default_nettype none

module phs_mix import phs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              spec,
    input  logic [BASE_W-1:0] power,
    input  side_t             side,
    input  gain_t             gain,
    output logic              out_valid,
    output shade_t            shade
);

    logic [MIX_STAGES-1:0] vld_reg;

    logic [OUT_W-1:0]   amb_a_reg [3];
    logic [SGL_W-1:0]   dgc_a_reg [3];
    logic [40:0]        sp_a_reg  [3];
    logic [NL_W-2:0]    nlp_a_reg;
    logic [OUT_W-1:0]   amb_b_reg [3];
    logic [44:0]        df_b_reg  [3];
    logic [15:0]        sp_b_reg  [3];
    logic [2:0][OUT_W-1:0] res_reg;

    logic [SGL_W-1:0]   amb_prod [3];
    logic [41:0]        sp_round [3];
    logic [45:0]        df_round [3];
    logic [20:0]        total    [3];
    logic [2:0][OUT_W-1:0] res_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            amb_prod[i] = SGL_W'(gain.ambient * side.col[i]) + SGL_W'(2048);
            sp_round[i] = 42'(sp_a_reg[i]) + 42'd33554432;
            df_round[i] = 46'(df_b_reg[i]) + 46'd33554432;
            total[i]    = 21'(amb_b_reg[i]) + 21'(df_round[i][45:26]) + 21'(sp_b_reg[i]);
            res_next[i] = (total[i] > 21'(OUT_MAX)) ? OUT_MAX : total[i][OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[MIX_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // A negative N.L contributes no diffuse light.
        nlp_a_reg <= side.nl[NL_W-1] ? '0 : side.nl[NL_W-2:0];
        for (int i = 0; i < 3; i++)
        begin
            amb_a_reg[i] <= amb_prod[i][SGL_W-1:COLOR_FRAC_BITS];
            dgc_a_reg[i] <= SGL_W'(gain.diffuse * side.col[i]);
            sp_a_reg[i]  <= spec ? 41'(gain.spec_light[i] * power) : '0;
            amb_b_reg[i] <= amb_a_reg[i];
            df_b_reg[i]  <= 45'(dgc_a_reg[i] * nlp_a_reg);
            sp_b_reg[i]  <= sp_round[i][41:26];
        end
        res_reg <= res_next;
    end

    assign out_valid       = vld_reg[MIX_STAGES-1];
    assign shade.out_red   = res_reg[0];
    assign shade.out_green = res_reg[1];
    assign shade.out_blue  = res_reg[2];

endmodule

`default_nettype wire

FILE: hdl/phong_shading_unit_top.sv
// An accepted transaction passes the vector, power and color stages and shows
// its result on shade with done high. Throughput: one transaction per cycle.
// The rate is set by the 17-stage pipeline (6 vector, 8 power, 3 color stages);
// busy is always low and the receiver cannot stall the block.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads the
// configuration registers with their default coefficients and white light.
`default_nettype none

module phong_shading_unit_top import phs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pixel_t                pixel,
    output logic                  done,
    output shade_t                shade,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The user must change these only while the pipeline is empty; unenforced.
    logic [COLOR_W-1:0] ambient_reg;
    logic [COLOR_W-1:0] diffuse_reg;
    logic [COLOR_W-1:0] specular_reg;
    logic [EXP_W-1:0]   shine_reg;
    logic [2:0][COLOR_W-1:0] light_reg;

    // The specular gain times the light color is a per-channel constant
    // between writes, so it is formed once here and registered, keeping the
    // color stages to one multiplier per path.
    logic [2:0][SGL_W-1:0] sgl_reg;

    logic   accept;
    logic   geom_valid;
    geom_t  geom_data;
    logic   pow_valid;
    logic   pow_spec;
    logic [BASE_W-1:0] pow_value;
    side_t  pow_side;
    gain_t  gain;

    // The pipeline never holds off a transaction.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg  <= RST_AMBIENT;
            diffuse_reg  <= RST_DIFFUSE;
            specular_reg <= RST_SPECULAR;
            shine_reg    <= RST_SHINE;
            light_reg    <= {RST_LIGHT, RST_LIGHT, RST_LIGHT};
        end
        else if (cfg_we)
        begin
            // Indexes beyond the register list are ignored.
            unique case (cfg_index)
                REG_AMBIENT:     ambient_reg  <= cfg_data;
                REG_DIFFUSE:     diffuse_reg  <= cfg_data;
                REG_SPECULAR:    specular_reg <= cfg_data;
                REG_SHINE:       shine_reg    <= cfg_data[EXP_W-1:0];
                REG_LIGHT_RED:   light_reg[0] <= cfg_data;
                REG_LIGHT_GREEN: light_reg[1] <= cfg_data;
                REG_LIGHT_BLUE:  light_reg[2] <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sgl_reg[i] <= SGL_W'(specular_reg * light_reg[i]);
        end
    end

    assign gain.ambient    = ambient_reg;
    assign gain.diffuse    = diffuse_reg;
    assign gain.spec_light = sgl_reg;

    // N.L, reflection vector, V.R and the clamped power base.
    phs_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel),
        .out_valid (geom_valid),
        .out_data  (geom_data)
    );

    // Raise the base to the shine exponent, one exponent bit per stage.
    phs_power u_power
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_data   (geom_data),
        .exponent  (shine_reg),
        .out_valid (pow_valid),
        .spec      (pow_spec),
        .power     (pow_value),
        .side      (pow_side)
    );

    // Ambient, diffuse and specular per channel, summed and saturated.
    phs_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pow_valid),
        .spec      (pow_spec),
        .power     (pow_value),
        .side      (pow_side),
        .gain      (gain),
        .out_valid (done),
        .shade     (shade)
    );

    // Every accepted transaction comes out at the end of the pipeline with done high.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted transaction did not complete on time");

    // No result appears without a matching accepted transaction.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching transaction");

    // A black pixel with zero vectors shades to black under any configuration.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (pixel == '0)) |-> ##LATENCY (shade == '0))
        else $error("black zero-vector pixel did not shade to black");

endmodule

`default_nettype wire

FILE: verif/phong_shading_unit_top_tb.sv
// Self-checking testbench for the Phong shading unit: directed and random fragments.
// Depends on hdl/phs_pkg.sv and hdl/phong_shading_unit_top.sv.
`timescale 1ns / 1ps

module phong_shading_unit_top_tb;
    import phs_pkg::*;

    // Register index that the block does not decode; a write to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    // Cycles without any accepted transaction or result before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS_PER_SETTING = 275;

    // Scoreboard: holds predicted shades in acceptance order and checks each result.
    class shade_scoreboard;
        shade_t expected_shades[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_pixel(shade_t predicted);
            expected_shades.push_back(predicted);
        endfunction

        function void check_shade(shade_t actual);
            shade_t want;
            if (expected_shades.size() == 0) begin
                $display("%0t: unexpected shade r=%0d g=%0d b=%0d", $time,
                         actual.out_red, actual.out_green, actual.out_blue);
                mismatches++;
                return;
            end
            want = expected_shades.pop_front();
            if (want.out_red !== actual.out_red) begin
                $display("%0t: out_red expected %0d actual %0d", $time,
                         want.out_red, actual.out_red);
                mismatches++;
            end
            if (want.out_green !== actual.out_green) begin
                $display("%0t: out_green expected %0d actual %0d", $time,
                         want.out_green, actual.out_green);
                mismatches++;
            end
            if (want.out_blue !== actual.out_blue) begin
                $display("%0t: out_blue expected %0d actual %0d", $time,
                         want.out_blue, actual.out_blue);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pixel_t                pixel;
    logic                  done;
    shade_t                shade;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    phong_shading_unit_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .shade     (shade),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    shade_scoreboard sb = new();

    // Shadow copy of the configuration registers, updated on every observed write.
    logic [COLOR_W-1:0] ka, kd, ks, light_r, light_g, light_b;
    logic [EXP_W-1:0]   shine;

    int pixels_sent;
    int idle_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round to nearest with ties toward +infinity, dropping s fraction bits.
    function automatic longint round_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [OUT_W-1:0] shade_channel(longint c, longint light, longint nl,
                                                       longint pw, bit spec);
        longint sum;
        sum = round_shift(longint'(ka) * c, COLOR_FRAC_BITS);
        // The diffuse term only counts for surfaces facing the light.
        if (nl > 0)
            sum += round_shift(longint'(kd) * nl * c, COLOR_FRAC_BITS + VEC_FRAC_BITS);
        if (spec)
            sum += round_shift(longint'(ks) * pw * light, COLOR_FRAC_BITS + VEC_FRAC_BITS);
        if (sum > longint'(OUT_MAX))
            sum = longint'(OUT_MAX);
        if (sum < 0)
            sum = 0;
        return sum[OUT_W-1:0];
    endfunction

    // Wide-integer Phong evaluation of one fragment with the current registers.
    function automatic shade_t phong_of(pixel_t p);
        longint v[3], n[3], l[3], r[3];
        longint acc, nl, vr, pw, b, unit;
        bit     spec;
        shade_t s;
        v[0] = longint'($signed(p.view_x));
        v[1] = longint'($signed(p.view_y));
        v[2] = longint'($signed(p.view_z));
        n[0] = longint'($signed(p.norm_x));
        n[1] = longint'($signed(p.norm_y));
        n[2] = longint'($signed(p.norm_z));
        l[0] = longint'($signed(p.ldir_x));
        l[1] = longint'($signed(p.ldir_y));
        l[2] = longint'($signed(p.ldir_z));
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += n[i] * l[i];
        nl = round_shift(acc, VEC_FRAC_BITS);
        for (int i = 0; i < 3; i++)
            r[i] = round_shift(2 * nl * n[i], VEC_FRAC_BITS) - l[i];
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += v[i] * r[i];
        vr = round_shift(acc, VEC_FRAC_BITS);
        unit = 64'sd1 <<< VEC_FRAC_BITS;
        spec = (vr > 0);
        pw = unit;
        if (spec)
        begin
            // Square-and-multiply over the exponent bits, base capped at 1.0.
            b = (vr > unit) ? unit : vr;
            for (int i = 0; i < EXP_W; i++)
            begin
                if (shine[i])
                    pw = round_shift(pw * b, VEC_FRAC_BITS);
                b = round_shift(b * b, VEC_FRAC_BITS);
            end
        end
        s.out_red   = shade_channel(longint'(p.surf_red), longint'(light_r), nl, pw, spec);
        s.out_green = shade_channel(longint'(p.surf_green), longint'(light_g), nl, pw, spec);
        s.out_blue  = shade_channel(longint'(p.surf_blue), longint'(light_b), nl, pw, spec);
        return s;
    endfunction

    // Monitor: everything is sampled at the rising edge, before the block's own updates.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ka      <= RST_AMBIENT;
            kd      <= RST_DIFFUSE;
            ks      <= RST_SPECULAR;
            shine   <= RST_SHINE;
            light_r <= RST_LIGHT;
            light_g <= RST_LIGHT;
            light_b <= RST_LIGHT;
            quiet_cycles <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AMBIENT:     ka      <= cfg_data;
                    REG_DIFFUSE:     kd      <= cfg_data;
                    REG_SPECULAR:    ks      <= cfg_data;
                    REG_SHINE:       shine   <= cfg_data[EXP_W-1:0];
                    REG_LIGHT_RED:   light_r <= cfg_data;
                    REG_LIGHT_GREEN: light_g <= cfg_data;
                    REG_LIGHT_BLUE:  light_b <= cfg_data;
                    default: ;
                endcase
            end
            // Configuration only changes while the pipeline is empty, so predicting
            // at acceptance time with the current shadow registers is exact.
            if (start && !busy)
                sb.note_pixel(phong_of(pixel));
            if (done)
                sb.check_shade(shade);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offers one fragment, inserting random idle cycles first, and returns once it
    // has been accepted. start stays high between back-to-back transactions.
    task automatic send_pixel(pixel_t p);
        idle_pct = (pixels_sent < 650) ? 37 : (pixels_sent < 1300) ? 46 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
        pixels_sent++;
    endtask

    // Holds off until every predicted shade has arrived and the pipeline has drained.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_shades.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] amb, logic [CFG_DATA_W-1:0] dif,
                               logic [CFG_DATA_W-1:0] spc, logic [CFG_DATA_W-1:0] shn,
                               logic [CFG_DATA_W-1:0] lr, logic [CFG_DATA_W-1:0] lg,
                               logic [CFG_DATA_W-1:0] lb);
        cfg_reg_e               regs[7];
        logic [CFG_DATA_W-1:0]  vals[7];
        regs = '{REG_AMBIENT, REG_DIFFUSE, REG_SPECULAR, REG_SHINE,
                 REG_LIGHT_RED, REG_LIGHT_GREEN, REG_LIGHT_BLUE};
        vals = '{amb, dif, spc, shn, lr, lg, lb};
        drain_pipeline();
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        // A write to an undecoded index must leave every register alone.
        cfg_index <= REG_UNMAPPED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VEC_W-1:0] to_q14(real x);
        return VEC_W'($rtoi(x * 16384.0));
    endfunction

    function automatic void random_unit(output real x, output real y, output real z);
        real m;
        x = real'($signed($urandom_range(2000)) - 1000);
        y = real'($signed($urandom_range(2000)) - 1000);
        z = real'($signed($urandom_range(2000)) - 1000);
        m = $sqrt(x * x + y * y + z * z);
        if (m < 1.0)
        begin
            x = 0.0; y = 0.0; z = 1.0; m = 1.0;
        end
        x = x / m; y = y / m; z = z / m;
    endfunction

    function automatic logic [COLOR_W-1:0] random_color();
        case ($urandom_range(9))
            0: return '0;
            1: return 13'd4096;
            2: return COLOR_W'($urandom);
            default: return COLOR_W'($urandom_range(4096));
        endcase
    endfunction

    // Mostly well-formed fragments (unit vectors, often with the viewer near the
    // mirror direction so the highlight is exercised); the rest is raw bit noise.
    function automatic pixel_t random_pixel();
        pixel_t p;
        real nx, ny, nz, lx, ly, lz, vx, vy, vz, d, m;
        p.surf_red   = random_color();
        p.surf_green = random_color();
        p.surf_blue  = random_color();
        if ($urandom_range(99) < 25)
        begin
            p.view_x = VEC_W'($urandom); p.view_y = VEC_W'($urandom);
            p.view_z = VEC_W'($urandom);
            p.norm_x = VEC_W'($urandom); p.norm_y = VEC_W'($urandom);
            p.norm_z = VEC_W'($urandom);
            p.ldir_x = VEC_W'($urandom); p.ldir_y = VEC_W'($urandom);
            p.ldir_z = VEC_W'($urandom);
            return p;
        end
        random_unit(nx, ny, nz);
        random_unit(lx, ly, lz);
        if ($urandom_range(99) < 60)
        begin
            d  = nx * lx + ny * ly + nz * lz;
            vx = 2.0 * d * nx - lx + real'($signed($urandom_range(400)) - 200) / 1000.0;
            vy = 2.0 * d * ny - ly + real'($signed($urandom_range(400)) - 200) / 1000.0;
            vz = 2.0 * d * nz - lz + real'($signed($urandom_range(400)) - 200) / 1000.0;
            m  = $sqrt(vx * vx + vy * vy + vz * vz);
            if (m < 0.001)
            begin
                vx = 0.0; vy = 0.0; vz = 1.0; m = 1.0;
            end
            vx = vx / m; vy = vy / m; vz = vz / m;
        end
        else
            random_unit(vx, vy, vz);
        p.view_x = to_q14(vx); p.view_y = to_q14(vy); p.view_z = to_q14(vz);
        p.norm_x = to_q14(nx); p.norm_y = to_q14(ny); p.norm_z = to_q14(nz);
        p.ldir_x = to_q14(lx); p.ldir_y = to_q14(ly); p.ldir_z = to_q14(lz);
        return p;
    endfunction

    function automatic pixel_t make_pixel(int c, int vx, int vy, int vz, int nx, int ny,
                                          int nz, int lx, int ly, int lz);
        pixel_t p;
        p.surf_red = COLOR_W'(c); p.surf_green = COLOR_W'(c); p.surf_blue = COLOR_W'(c);
        p.view_x = VEC_W'(vx); p.view_y = VEC_W'(vy); p.view_z = VEC_W'(vz);
        p.norm_x = VEC_W'(nx); p.norm_y = VEC_W'(ny); p.norm_z = VEC_W'(nz);
        p.ldir_x = VEC_W'(lx); p.ldir_y = VEC_W'(ly); p.ldir_z = VEC_W'(lz);
        return p;
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    initial
    begin
        pixel_t p;
        rst_n       = 1'b0;
        start       = 1'b0;
        pixel       = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_AMBIENT;
        cfg_data    = '0;
        pixels_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed fragments under the reset configuration.
        // Head-on light and view: full diffuse and specular.
        send_pixel(make_pixel(4096, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        // Light behind the surface: diffuse is dropped.
        send_pixel(make_pixel(4096, 0, 0, 16384, 0, 0, 16384, 0, 0, -16384));
        // Viewer facing away from the reflection: no highlight.
        send_pixel(make_pixel(4096, 0, 0, -16384, 0, 0, 16384, 11585, 0, 11585));
        // Oversized vectors push V.R above one, so the base saturates.
        send_pixel(make_pixel(8191, 32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767));
        send_pixel(make_pixel(8191, -32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768));
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(8191, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(4096, 16384, 0, 0, 16384, 0, 0, 16384, 0, 0));
        send_pixel(make_pixel(2048, 0, 16384, 0, 0, 11585, 11585, 0, 0, 16384));
        send_pixel(make_pixel(4096, -16384, -16384, -16384, 16384, 16384, 16384,
                              -16384, -16384, -16384));
        p = make_pixel(0, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384);
        p.surf_red = 13'd8191;
        p.surf_blue = 13'd4096;
        send_pixel(p);
        random_burst(RAND_ITEMS_PER_SETTING - 11);

        // Everything off and zero exponent: every term is zero, so the shade is black.
        load_config(0, 0, 0, 0, 0, 0, 0);
        send_pixel(make_pixel(4096, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        random_burst(RAND_ITEMS_PER_SETTING);

        // Unit coefficients, top exponent and white light.
        load_config(4096, 4096, 4096, 255, 4096, 4096, 4096);
        random_burst(RAND_ITEMS_PER_SETTING);

        // Zero exponent with strong gains: any positive V.R gives a full highlight.
        load_config(4096, 2048, 4096, 0, 4096, 2048, 1024);
        send_pixel(make_pixel(4096, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        random_burst(RAND_ITEMS_PER_SETTING);

        // Exponent of one and random settings of at most 1.0, then fully random ones.
        load_config(13'($urandom_range(4096)), 13'($urandom_range(4096)),
                    13'($urandom_range(4096)), 1, 13'($urandom_range(4096)),
                    13'($urandom_range(4096)), 13'($urandom_range(4096)));
        random_burst(RAND_ITEMS_PER_SETTING);

        load_config(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
                    13'($urandom), 13'($urandom), 13'($urandom));
        random_burst(RAND_ITEMS_PER_SETTING);

        // All-ones data in every register, so the output saturates often.
        load_config(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        random_burst(RAND_ITEMS_PER_SETTING);

        drain_pipeline();
        if (sb.mismatches == 0 && sb.expected_shades.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/phs_pkg.sv
hdl/phs_geom.sv
hdl/phs_power.sv
hdl/phs_mix.sv
hdl/phong_shading_unit_top.sv
verif/phong_shading_unit_top_tb.sv
